[src/ilp_pkg.sv]
package ilp_pkg;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // one finished token
  typedef struct packed {
    logic [63:0] value;
    logic        bad_underscore;
    logic [7:0]  consumed;
  } ilp_result_t;

endpackage

[src/ilp_core.sv]
module ilp_core #(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 last,
  input  logic                 func,
  output ilp_pkg::ilp_result_t result
);

  localparam int CapInt = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [7:0] CountCap = CapInt[7:0];

  typedef enum logic [2:0] {
    P_START, P_SIGNED, P_ZERO, P_DEC, P_HEXSTART, P_HEX, P_DONE, P_DONE_ERR
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] accum, accum_next;
  logic [63:0] naccum, naccum_next;   // running negation of accum
  logic        is_minus, is_minus_next;
  logic        is_wide, is_wide_next;
  logic        upend, upend_next;
  logic [7:0]  char_count, char_count_next;

  logic        is_dec, is_hexl, dig_ok, run, run_hex, take, handled;
  logic [3:0]  dval;
  logic [1:0]  inc;
  logic [63:0] acc_step, nacc_step, acc_sel, nacc_sel, v;
  logic [8:0]  sum;
  logic [7:0]  cnt_sat;
  logic        err;

  always_comb begin
    is_dec  = (ch >= ilp_pkg::CH_ZERO) && (ch <= ilp_pkg::CH_NINE);
    is_hexl = ((ch >= ilp_pkg::CH_LO_A) && (ch <= ilp_pkg::CH_LO_F)) ||
              ((ch >= ilp_pkg::CH_UP_A) && (ch <= ilp_pkg::CH_UP_F));
    // '0'-'9' low nibble is the digit, letters are low nibble plus nine
    dval = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

    phase_next    = phase;
    is_minus_next = is_minus;
    is_wide_next  = is_wide;
    upend_next    = upend;
    inc           = 2'd0;
    take          = 1'b0;
    run           = 1'b0;
    run_hex       = 1'b0;
    handled       = 1'b0;
    dig_ok        = 1'b0;

    if (phase == P_START) begin
      is_wide_next = func;
      if ((ch == ilp_pkg::CH_MINUS) || (ch == ilp_pkg::CH_PLUS)) begin
        is_minus_next = (ch == ilp_pkg::CH_MINUS);
        inc           = 2'd1;
        handled       = 1'b1;
      end
      phase_next = P_SIGNED;
    end

    if (!handled) begin
      unique case (phase_next)
        P_SIGNED: begin
          if (ch == ilp_pkg::CH_UNDER) phase_next = P_DONE_ERR;
          else if (ch == ilp_pkg::CH_ZERO) phase_next = P_ZERO;
          else begin
            phase_next = P_DEC;
            run        = 1'b1;
          end
        end
        P_ZERO: begin
          if (ch == ilp_pkg::CH_X) begin
            inc        = 2'd2;
            phase_next = P_HEXSTART;
          end else begin
            // the leading zero counts; accum is still zero so times ten is a no-op
            phase_next = P_DEC;
            inc        = 2'd1;
            run        = 1'b1;
          end
        end
        P_HEXSTART: begin
          if (ch == ilp_pkg::CH_UNDER) phase_next = P_DONE_ERR;
          else begin
            phase_next = P_HEX;
            run        = 1'b1;
            run_hex    = 1'b1;
          end
        end
        P_DEC, P_HEX: begin
          run     = 1'b1;
          run_hex = (phase_next == P_HEX);
        end
        P_START, P_DONE, P_DONE_ERR: begin
        end
      endcase
    end

    if (run) begin
      dig_ok = is_dec || (run_hex && is_hexl);
      if (upend) begin
        upend_next = 1'b0;
        if (dig_ok) begin
          inc  = inc + 2'd2;
          take = 1'b1;
        end else begin
          phase_next = P_DONE_ERR;
        end
      end else if (dig_ok) begin
        inc  = inc + 2'd1;
        take = 1'b1;
      end else if (ch == ilp_pkg::CH_UNDER) begin
        upend_next = 1'b1;
      end else begin
        phase_next = P_DONE;
      end
    end

    // one digit step on both the value and its negation
    if (run_hex) begin
      acc_step  = {accum[59:0], 4'b0000} + {60'd0, dval};
      nacc_step = {naccum[59:0], 4'b0000} - {60'd0, dval};
    end else begin
      acc_step  = (accum << 3) + (accum << 1) + {60'd0, dval};
      nacc_step = (naccum << 3) + (naccum << 1) - {60'd0, dval};
    end
    if (!is_wide_next) begin
      acc_step[63:32]  = 32'd0;
      nacc_step[63:32] = 32'd0;
    end
    acc_sel  = take ? acc_step : accum;
    nacc_sel = take ? nacc_step : naccum;

    // closing the token
    if (last) begin
      if (phase_next == P_ZERO) inc = inc + 2'd1;
      if (upend_next) phase_next = P_DONE_ERR;
    end

    sum     = {1'b0, char_count} + {7'd0, inc};
    cnt_sat = (sum > {1'b0, CountCap}) ? CountCap : sum[7:0];

    err = (phase_next == P_DONE_ERR);
    v   = is_minus_next ? nacc_sel : acc_sel;
    if (!is_wide_next) v = {{32{v[31]}}, v[31:0]};
    if (err) v = 64'd0;

    result.value          = v;
    result.bad_underscore = err;
    result.consumed       = cnt_sat;

    accum_next      = acc_sel;
    naccum_next     = nacc_sel;
    char_count_next = cnt_sat;
    if (last) begin
      phase_next      = P_START;
      accum_next      = 64'd0;
      naccum_next     = 64'd0;
      is_minus_next   = 1'b0;
      is_wide_next    = 1'b0;
      upend_next      = 1'b0;
      char_count_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_START;
      accum      <= 64'd0;
      naccum     <= 64'd0;
      is_minus   <= 1'b0;
      is_wide    <= 1'b0;
      upend      <= 1'b0;
      char_count <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      accum      <= accum_next;
      naccum     <= naccum_next;
      is_minus   <= is_minus_next;
      is_wide    <= is_wide_next;
      upend      <= upend_next;
      char_count <= char_count_next;
    end
  end

endmodule

[src/int_literal_parser.sv]
// integer literal parser, one character per transfer
// a closing character sits in the input register, then fills the result register
// throughput: one character per cycle outside output stalls; set by the combinational
//   digit step (shift-add on the 64-bit accumulator and its negation) in ilp_core
// reset: synchronous active-high rst empties the input and result registers and
//   returns the token state to start of token
module int_literal_parser #(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        func,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic        bad_underscore,
  output logic [7:0]  consumed
);

  // input register
  logic       q_valid;
  logic [7:0] ch_q;
  logic       last_q;
  logic       func_q;

  logic out_free;   // result register can take a new result this cycle
  logic advance;    // registered character is processed this cycle

  ilp_pkg::ilp_result_t result;

  // a character without last never waits; a closing one needs room in the
  // result register, which frees up in the same cycle its result transfers
  assign out_free = !out_valid || !out_stall;
  assign advance  = q_valid && (!last_q || out_free);
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_q   <= ch;
      last_q <= last;
      func_q <= func;
    end
  end

  // token state and per-character step
  ilp_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .ch    (ch_q),
    .last  (last_q),
    .func  (func_q),
    .result(result)
  );

  // result register, loaded only by a closing character
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && last_q) begin
      value          <= result.value;
      bad_underscore <= result.bad_underscore;
      consumed       <= result.consumed;
    end
  end

endmodule

[src/ilp_checker.sv]
module ilp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] value,
  input logic        bad_underscore
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a fresh result must trace back to a transferred closing character
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
    else $error("result without closing character");

  // a misplaced underscore forces a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_underscore |-> value == 64'd0)
    else $error("error result with nonzero value");

endmodule

bind int_literal_parser ilp_checker u_ilp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .last          (last),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .value         (value),
  .bad_underscore(bad_underscore)
);
